// ===== src/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/hpc_pkg.sv =====
package hpc_pkg;
	localparam int MAX_CANDIDATES = 8;
	localparam int SLOT_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam int PROBE_LIMIT = 8;

	localparam logic [2:0] K_START = 3'd0;
	localparam logic [2:0] K_TICK = 3'd1;
	localparam logic [2:0] K_CAND = 3'd2;
	localparam logic [2:0] K_CDONE = 3'd3;
	localparam logic [2:0] K_SYNCRX = 3'd4;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_GATHER = 3'd1;
	localparam logic [2:0] PH_CONNECT = 3'd2;
	localparam logic [2:0] PH_SYNC = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;
	localparam logic [2:0] PH_FAIL = 3'd5;

	localparam logic [1:0] ACT_STATUS = 2'd0;
	localparam logic [1:0] ACT_CONNECT = 2'd1;
	localparam logic [1:0] ACT_SYNC = 2'd2;
	localparam logic [1:0] ACT_PROBE = 2'd3;

	localparam logic [2:0] R_TIMEOUT = 3'd0;
	localparam logic [2:0] R_RETRY = 3'd1;
	localparam logic [2:0] R_MAXSYNC = 3'd2;
	localparam logic [2:0] R_MAXATT = 3'd3;
	localparam logic [2:0] R_BACKOFF = 3'd4;
	localparam logic [2:0] R_PEERV6 = 3'd5;
	localparam logic [2:0] R_PEERHI = 3'd6;
	localparam logic [2:0] R_PEERLO = 3'd7;

	// one candidate table entry
	typedef struct packed {
		logic        v6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [15:0] port;
		logic [2:0]  attempts;
		logic [31:0] last_try;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  slot;
		logic [2:0]  attempt;
		logic        v6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [15:0] port;
		logic [2:0]  phase;
		logic        last;
	} result_t;

	localparam int RES_W = $bits(result_t);
	localparam int ENT_W = $bits(entry_t);
endpackage

// ===== src/hole_punch_controller.sv =====
// channel   | dir | payload
// s_axis    | in  | kind, now_ms, flags, candidate address and port
// m_axis    | out | action, slot, attempt, probe address, session_state; tlast
// cfg       | in  | register index and write data
// an input passes through accept and status; a probe walk adds a read and then
// a check and write back per stored candidate, plus a closing read and a post
// step, and CONNECT or the connect-done SYNC adds a pre step
// the walk is set by the single read port of the candidate table ram
// reset returns registers to their defaults and the session to idle
// output stalls hold the sequencer; the next input is refused meanwhile
`include "assert_macros.svh"
module hole_punch_controller import hpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// kind[2:0], now_ms[34:3], link_connected[35], peer_established[36],
	// cand_is_v6[37], cand_addr_high[101:38], cand_addr_low[165:102],
	// cand_port[181:166], zero to 183
	input  logic [183:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// action[1:0], slot[4:2], attempt[7:5], probe_is_v6[8],
	// probe_addr_high[72:9], probe_addr_low[136:73], probe_port[152:137],
	// session_state[155:153], zero to 159
	output logic [159:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_PRE, S_RD, S_CHK, S_POST, S_STATUS
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] timeout_q;
	logic [15:0] retry_q;
	logic [4:0]  max_syncs_q;
	logic [2:0]  max_att_q;
	logic [9:0]  backoff_q;
	logic        peer_v6_q;
	logic [63:0] peer_hi_q, peer_lo_q;

	// session state
	logic [2:0]       phase_q;
	logic [31:0]      start_q, last_sync_q;
	logic [4:0]       syncs_q;
	logic [CNT_W-1:0] count_q;

	// latched request
	logic [2:0]  kind_q;
	logic [31:0] now_q;
	logic [CNT_W-1:0] idx_q;
	logic [3:0]  probes_q;
	logic        pre_sync_q;   // CONNECT, or the connect-done SYNC before the walk
	logic        post_sync_q;  // connecting SYNC after the walk

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd10000;
			retry_q <= 16'd100;
			max_syncs_q <= 5'd20;
			max_att_q <= 3'd5;
			backoff_q <= 10'd50;
			peer_v6_q <= 1'b0;
			peer_hi_q <= '0;
			peer_lo_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				R_TIMEOUT: timeout_q <= cfg_data[31:0];
				R_RETRY:   retry_q <= cfg_data[15:0];
				R_MAXSYNC: max_syncs_q <= cfg_data[4:0];
				R_MAXATT:  max_att_q <= cfg_data[2:0];
				R_BACKOFF: backoff_q <= cfg_data[9:0];
				R_PEERV6:  peer_v6_q <= cfg_data[0];
				R_PEERHI:  peer_hi_q <= cfg_data;
				R_PEERLO:  peer_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input fields
	logic [2:0]  in_kind;
	logic [31:0] in_now;
	logic        in_link, in_est, in_v6;
	logic [63:0] in_hi, in_lo;
	logic [15:0] in_port;
	assign in_kind = s_axis_tdata[2:0];
	assign in_now = s_axis_tdata[34:3];
	assign in_link = s_axis_tdata[35];
	assign in_est = s_axis_tdata[36];
	assign in_v6 = s_axis_tdata[37];
	assign in_hi = s_axis_tdata[101:38];
	assign in_lo = s_axis_tdata[165:102];
	assign in_port = s_axis_tdata[181:166];

	assign s_axis_tready = (state_q == S_IDLE);
	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;

	// trust filter
	logic trusted;
	always_comb begin
		trusted = 1'b0;
		if (in_est) begin
			trusted = 1'b1;
		end else if (!in_v6) begin
			if (in_lo[31:0] == 32'h7f000001) begin
				trusted = 1'b1;
			end else if (!peer_v6_q && (peer_lo_q[31:8] == in_lo[31:8])) begin
				trusted = 1'b1;
			end
		end else if (peer_v6_q && in_hi == peer_hi_q && in_lo[63:16] == peer_lo_q[63:16]) begin
			trusted = 1'b1;
		end
	end

	logic active;
	assign active = (phase_q == PH_GATHER) || (phase_q == PH_CONNECT) || (phase_q == PH_SYNC);

	// candidate table
	logic              tbl_we;
	logic [SLOT_W-1:0] tbl_waddr, tbl_raddr;
	entry_t            tbl_wdata, tbl_rdata;

	hpc_table u_table (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	assign tbl_raddr = idx_q[SLOT_W-1:0];

	// probe check on the read entry
	logic [12:0] wait_ms;
	logic [31:0] since;
	logic        do_probe;
	logic [2:0]  att_next;
	assign wait_ms = 13'(({10'd0, tbl_rdata.attempts} + 13'd1) * {3'd0, backoff_q});
	assign since = now_q - tbl_rdata.last_try;
	assign do_probe = (tbl_rdata.attempts < max_att_q) && (since >= {19'd0, wait_ms});
	assign att_next = tbl_rdata.attempts + 3'd1;

	// result stage
	logic    res_valid, res_ready;
	result_t res_data, out_data;

	hpc_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .in_valid(res_valid), .in_ready(res_ready),
		.in_data(res_data), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(out_data)
	);

	assign m_axis_tdata = {4'd0, out_data.phase, out_data.port, out_data.addr_low,
		out_data.addr_high, out_data.v6, out_data.attempt, out_data.slot,
		out_data.action};
	assign m_axis_tlast = out_data.last;

	logic walk_done;
	assign walk_done = (idx_q >= count_q) || (probes_q >= 4'(PROBE_LIMIT));

	always_comb begin
		res_valid = 1'b0;
		res_data = '0;
		res_data.phase = phase_q;
		tbl_we = 1'b0;
		tbl_waddr = idx_q[SLOT_W-1:0];
		tbl_wdata = tbl_rdata;
		case (state_q)
			S_PRE: begin
				res_valid = pre_sync_q;
				res_data.action = (kind_q == K_TICK) ? ACT_CONNECT : ACT_SYNC;
			end
			S_CHK: begin
				if (do_probe) begin
					res_valid = 1'b1;
					res_data.action = ACT_PROBE;
					res_data.slot = 3'(idx_q);
					res_data.attempt = att_next;
					res_data.v6 = tbl_rdata.v6;
					res_data.addr_high = tbl_rdata.addr_high;
					res_data.addr_low = tbl_rdata.addr_low;
					res_data.port = tbl_rdata.port;
					tbl_we = res_ready;
					tbl_wdata.attempts = att_next;
					tbl_wdata.last_try = now_q;
				end
			end
			S_POST: begin
				res_valid = post_sync_q;
				res_data.action = ACT_SYNC;
			end
			S_STATUS: begin
				res_valid = 1'b1;
				res_data.action = ACT_STATUS;
				res_data.last = 1'b1;
			end
			default: begin
				if (accept && in_kind == K_CAND && count_q < CNT_W'(MAX_CANDIDATES)
						&& trusted) begin
					tbl_we = 1'b1;
					tbl_waddr = count_q[SLOT_W-1:0];
					tbl_wdata.v6 = in_v6;
					tbl_wdata.addr_high = in_v6 ? in_hi : 64'd0;
					tbl_wdata.addr_low = in_v6 ? in_lo : {32'd0, in_lo[31:0]};
					tbl_wdata.port = in_port;
					tbl_wdata.attempts = 3'd0;
					tbl_wdata.last_try = 32'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			start_q <= '0;
			last_sync_q <= '0;
			syncs_q <= '0;
			count_q <= '0;
			kind_q <= '0;
			now_q <= '0;
			idx_q <= '0;
			probes_q <= '0;
			pre_sync_q <= 1'b0;
			post_sync_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= in_kind;
						now_q <= in_now;
						idx_q <= '0;
						probes_q <= '0;
						pre_sync_q <= 1'b0;
						post_sync_q <= 1'b0;
						state_q <= S_STATUS;
						case (in_kind)
							K_START: begin
								phase_q <= PH_GATHER;
								start_q <= in_now;
								last_sync_q <= '0;
								syncs_q <= '0;
								count_q <= '0;
							end
							K_TICK: begin
								if (active) begin
									if (in_now - start_q > timeout_q) begin
										phase_q <= PH_FAIL;
									end else if (phase_q == PH_GATHER) begin
										phase_q <= PH_CONNECT;
										last_sync_q <= in_now;
										pre_sync_q <= 1'b1;
										state_q <= S_PRE;
									end else begin
										// walk first; phase set from the link now
										if (in_link) begin
											phase_q <= PH_DONE;
										end else if (phase_q == PH_CONNECT
												&& in_now - last_sync_q > {16'd0, retry_q}) begin
											last_sync_q <= in_now;
											if (syncs_q < max_syncs_q) begin
												post_sync_q <= 1'b1;
												syncs_q <= syncs_q + 5'd1;
											end
										end
										state_q <= S_RD;
									end
								end
							end
							K_CAND: begin
								if (count_q < CNT_W'(MAX_CANDIDATES) && trusted) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							K_CDONE: begin
								phase_q <= PH_SYNC;
								start_q <= in_now;
								pre_sync_q <= 1'b1;
								state_q <= S_PRE;
							end
							K_SYNCRX: begin
								if (phase_q == PH_CONNECT) begin
									state_q <= S_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_PRE: begin
					if (res_ready) begin
						state_q <= (kind_q == K_TICK) ? S_STATUS : S_RD;
					end
				end
				S_RD: begin
					state_q <= walk_done ? S_POST : S_CHK;
				end
				S_CHK: begin
					if (!do_probe || res_ready) begin
						if (do_probe) begin
							probes_q <= probes_q + 4'd1;
						end
						idx_q <= idx_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_POST: begin
					if (!post_sync_q || res_ready) begin
						state_q <= S_STATUS;
					end
				end
				S_STATUS: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_busy_no_accept, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_CANDIDATES))
	`ASSERT_IMPL(a_write_probe, clk, arst_n, state_q == S_CHK && tbl_we, res_valid && res_ready)
	`ASSERT_NEXT(a_status_end, clk, arst_n, state_q == S_STATUS && res_ready, state_q == S_IDLE)
endmodule

// ===== src/hpc_table.sv =====
module hpc_table import hpc_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic [SLOT_W-1:0] raddr,
	output entry_t            rdata
);
	entry_t mem [MAX_CANDIDATES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/hpc_out_reg.sv =====
module hpc_out_reg import hpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	logic valid_q;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_data <= in_data;
		end
	end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import hpc_pkg::*;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] now;
		logic        link;
		logic        est;
		logic        v6;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [15:0] port;
	} request_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [183:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [159:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = R_TIMEOUT;
	logic [63:0]  cfg_data = '0;

	hole_punch_controller dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// pending requests and predicted results
	request_t request_q[$];
	request_t cur_req;
	result_t  expected_q[$];
	int       errors = 0;
	int       n_requests = 0;
	int       n_results = 0;
	int       n_probes = 0;
	int       n_cfg = 0;
	bit       no_idle = 0;
	bit       hold_go = 0;
	bit       req_taken = 0;

	// mirror of the controller registers and session
	logic [31:0] m_timeout;
	logic [15:0] m_retry;
	logic [4:0]  m_max_syncs;
	logic [2:0]  m_max_att;
	logic [9:0]  m_backoff;
	logic        m_peer_v6;
	logic [63:0] m_peer_hi, m_peer_lo;
	logic [2:0]  m_phase;
	logic [31:0] m_start, m_last_sync;
	logic [4:0]  m_syncs;
	int          m_count;
	entry_t      m_tab[MAX_CANDIDATES];

	task automatic mirror_reset();
		m_timeout = 10000;
		m_retry = 100;
		m_max_syncs = 20;
		m_max_att = 5;
		m_backoff = 50;
		m_peer_v6 = 0;
		m_peer_hi = 0;
		m_peer_lo = 0;
		m_phase = PH_IDLE;
		m_start = 0;
		m_last_sync = 0;
		m_syncs = 0;
		m_count = 0;
	endtask

	function automatic result_t plain(logic [1:0] act);
		result_t r;
		r = '0;
		r.action = act;
		return r;
	endfunction

	// walk the table, probing candidates whose backoff has expired
	task automatic predict_probes(logic [31:0] now, inout result_t res[$]);
		int probes;
		logic [31:0] wait_ms;
		result_t r;
		probes = 0;
		for (int i = 0; i < m_count; i++) begin
			if (probes >= PROBE_LIMIT) break;
			if (m_tab[i].attempts >= m_max_att) continue;
			wait_ms = (32'(m_tab[i].attempts) + 1) * 32'(m_backoff);
			if (now - m_tab[i].last_try < wait_ms) continue;
			m_tab[i].last_try = now;
			m_tab[i].attempts = m_tab[i].attempts + 1;
			r = plain(ACT_PROBE);
			r.slot = 3'(i);
			r.attempt = m_tab[i].attempts;
			r.v6 = m_tab[i].v6;
			r.addr_high = m_tab[i].addr_high;
			r.addr_low = m_tab[i].addr_low;
			r.port = m_tab[i].port;
			res.push_back(r);
			probes++;
		end
	endtask

	function automatic bit is_trusted(request_t q);
		if (q.est) return 1;
		if (!q.v6) begin
			if (q.lo[31:0] == 32'h7f000001) return 1;
			return !m_peer_v6 && m_peer_lo[31:8] == q.lo[31:8];
		end
		return m_peer_v6 && q.hi == m_peer_hi && q.lo[63:16] == m_peer_lo[63:16];
	endfunction

	// session behavior for one request; queues every result it causes
	task automatic predict_session(request_t q);
		result_t res[$];
		case (q.kind)
			K_START: begin
				m_phase = PH_GATHER;
				m_start = q.now;
				m_last_sync = 0;
				m_syncs = 0;
				m_count = 0;
			end
			K_TICK: begin
				if (m_phase == PH_GATHER || m_phase == PH_CONNECT || m_phase == PH_SYNC) begin
					if (q.now - m_start > m_timeout) m_phase = PH_FAIL;
					else if (m_phase == PH_GATHER) begin
						m_phase = PH_CONNECT;
						m_last_sync = q.now;
						res.push_back(plain(ACT_CONNECT));
					end else if (m_phase == PH_CONNECT) begin
						predict_probes(q.now, res);
						if (q.link) m_phase = PH_DONE;
						else if (q.now - m_last_sync > 32'(m_retry)) begin
							m_last_sync = q.now;
							if (m_syncs < m_max_syncs) begin
								res.push_back(plain(ACT_SYNC));
								m_syncs++;
							end
						end
					end else begin
						predict_probes(q.now, res);
						if (q.link) m_phase = PH_DONE;
					end
				end
			end
			K_CAND: begin
				if (m_count < MAX_CANDIDATES && is_trusted(q)) begin
					m_tab[m_count].v6 = q.v6;
					m_tab[m_count].addr_high = q.v6 ? q.hi : 64'd0;
					m_tab[m_count].addr_low = q.v6 ? q.lo : {32'd0, q.lo[31:0]};
					m_tab[m_count].port = q.port;
					m_tab[m_count].attempts = 0;
					m_tab[m_count].last_try = 0;
					m_count++;
				end
			end
			K_CDONE: begin
				m_phase = PH_SYNC;
				m_start = q.now;
				res.push_back(plain(ACT_SYNC));
				predict_probes(q.now, res);
			end
			K_SYNCRX: if (m_phase == PH_CONNECT) predict_probes(q.now, res);
			default: ;
		endcase
		res.push_back(plain(ACT_STATUS));
		res[$].last = 1;
		foreach (res[i]) begin
			res[i].phase = m_phase;
			expected_q.push_back(res[i]);
		end
	endtask

	task automatic mirror_cfg(logic [2:0] idx, logic [63:0] v);
		case (idx)
			R_TIMEOUT: m_timeout = v[31:0];
			R_RETRY:   m_retry = v[15:0];
			R_MAXSYNC: m_max_syncs = v[4:0];
			R_MAXATT:  m_max_att = v[2:0];
			R_BACKOFF: m_backoff = v[9:0];
			R_PEERV6:  m_peer_v6 = v[0];
			R_PEERHI:  m_peer_hi = v;
			R_PEERLO:  m_peer_lo = v;
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch on result %0d: %s got %0h want %0h", n_results, what, got, want);
	endtask

	// request driver: one handshake per item, random gap after each
	int send_gap = 0;
	always @(negedge clk) begin
		logic nv;
		if (arst_n && !(s_axis_tvalid && !req_taken)) begin
			nv = 0;
			if (send_gap > 0) send_gap--;
			else if (request_q.size() > 0) begin
				cur_req = request_q.pop_front();
				s_axis_tdata <= {2'b0, cur_req.port, cur_req.lo, cur_req.hi, cur_req.v6,
					cur_req.est, cur_req.link, cur_req.now, cur_req.kind};
				nv = 1;
				send_gap = no_idle ? 0 : $urandom_range(0, 8);
			end
			s_axis_tvalid <= nv;
		end
	end

	// result receiver: random stall per result, one long hold-off on demand
	int recv_gap = 0;
	int hold_cnt = 0;
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go = 0;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
			if (m_axis_tvalid) recv_gap = no_idle ? 0 : $urandom_range(0, 8);
		end
	end

	// accepted requests feed the predictor; accepted results are checked
	always @(posedge clk) begin
		result_t got, want;
		req_taken = s_axis_tvalid && s_axis_tready;
		if (req_taken) begin
			n_requests++;
			predict_session(cur_req);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[1:0], m_axis_tdata[4:2], m_axis_tdata[7:5], m_axis_tdata[8],
				m_axis_tdata[72:9], m_axis_tdata[136:73], m_axis_tdata[152:137],
				m_axis_tdata[155:153], m_axis_tlast};
			n_results++;
			if (got.action == ACT_PROBE) n_probes++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("unexpected result %0d, action %0d", n_results, got.action);
			end else begin
				want = expected_q.pop_front();
				if (got.action !== want.action) report("action", got.action, want.action);
				if (got.slot !== want.slot) report("slot", got.slot, want.slot);
				if (got.attempt !== want.attempt) report("attempt", got.attempt, want.attempt);
				if (got.v6 !== want.v6) report("probe_is_v6", got.v6, want.v6);
				if (got.addr_high !== want.addr_high)
					report("probe_addr_high", got.addr_high, want.addr_high);
				if (got.addr_low !== want.addr_low)
					report("probe_addr_low", got.addr_low, want.addr_low);
				if (got.port !== want.port) report("probe_port", got.port, want.port);
				if (got.phase !== want.phase) report("session_state", got.phase, want.phase);
				if (got.last !== want.last) report("tlast", got.last, want.last);
			end
		end
	end

	// watchdog on cycles without any handshake
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			quiet = 0;
		else if (arst_n && ++quiet >= 5000) begin
			$display("FAIL hole_punch_controller");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		mirror_cfg(idx, v);
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// sender pause: everything out, every result back, plus slack
	task automatic drain();
		while (request_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic request_t mk(logic [2:0] k, logic [31:0] t);
		request_t q;
		q.kind = k;
		q.now = t;
		q.link = 0;
		q.est = 0;
		q.v6 = 0;
		q.hi = 0;
		q.lo = 0;
		q.port = 0;
		return q;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// candidate mostly passing the trust filter under the current peer
	function automatic request_t mk_cand(logic [31:0] t);
		request_t q;
		q = mk(K_CAND, t);
		q.v6 = $urandom_range(0, 1);
		q.hi = rnd64();
		q.lo = rnd64();
		q.port = $urandom;
		case ($urandom_range(0, 4))
			0: q.est = 1;
			1: q.lo[31:0] = 32'h7f000001;
			2, 3: begin
				if (m_peer_v6) begin
					q.v6 = 1;
					q.hi = m_peer_hi;
					q.lo[63:16] = m_peer_lo[63:16];
				end else begin
					q.v6 = 0;
					q.lo[31:8] = m_peer_lo[31:8];
				end
			end
			default: ;
		endcase
		return q;
	endfunction

	// one session: start, candidates, then timed events with random content
	task automatic add_session(int n_events);
		logic [31:0] t;
		request_t q;
		t = $urandom;
		request_q.push_back(mk(K_START, t));
		repeat ($urandom_range(0, 10)) request_q.push_back(mk_cand(t));
		for (int i = 0; i < n_events; i++) begin
			t += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 300);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					q = mk(K_TICK, t);
					q.link = ($urandom_range(0, 9) == 0);
				end
				4: q = mk(K_SYNCRX, t);
				5: q = mk(K_CDONE, t);
				6: q = mk_cand(t);
				default: begin
					q = mk(3'($urandom_range(0, 7)), $urandom);
					q.link = $urandom;
					q.est = $urandom;
					q.v6 = $urandom;
					q.hi = rnd64();
					q.lo = rnd64();
					q.port = $urandom;
				end
			endcase
			request_q.push_back(q);
		end
	endtask

	task automatic random_phase(int n);
		int target;
		target = n_requests + n;
		while (n_requests < target) begin
			add_session($urandom_range(4, 14));
			while (request_q.size() > 4) @(posedge clk);
		end
	endtask

	initial begin
		request_t q;
		mirror_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: full session under default registers
		request_q.push_back(mk(K_START, 0));
		q = mk(K_CAND, 0);
		q.lo = 64'hffffffff_7f000001;
		q.port = 16'hffff;
		request_q.push_back(q);
		q = mk(K_CAND, 0);
		q.lo = 64'h0000_0000_0000_00ab;
		request_q.push_back(q);
		q = mk(K_CAND, 0);
		q.lo = 64'h0000_0000_0101_0101;
		request_q.push_back(q);
		q = mk(K_CAND, 0);
		q.est = 1;
		q.v6 = 1;
		q.hi = '1;
		q.lo = '1;
		q.port = 16'hffff;
		request_q.push_back(q);
		request_q.push_back(mk(K_TICK, 10));
		request_q.push_back(mk(K_TICK, 160));
		request_q.push_back(mk(K_SYNCRX, 400));
		request_q.push_back(mk(3'd5, 410));
		request_q.push_back(mk(3'd6, 420));
		request_q.push_back(mk(3'd7, 430));
		request_q.push_back(mk(K_CDONE, 700));
		q = mk(K_TICK, 900);
		q.link = 1;
		request_q.push_back(q);
		request_q.push_back(mk(K_TICK, 1000));
		request_q.push_back(mk(K_SYNCRX, 1100));
		request_q.push_back(mk(K_START, 32'hffff_fff0));
		request_q.push_back(mk(K_TICK, 32'h0000_0010));
		request_q.push_back(mk(K_TICK, 32'h0000_3000));
		request_q.push_back(mk(K_TICK, 32'h0000_3100));
		drain();

		// defaults with idling, then a long output hold-off under pressure
		random_phase(40);
		hold_go = 1;
		random_phase(15);
		drain();

		// all-zero extremes, no idling
		no_idle = 1;
		for (int r = 0; r < 8; r++) write_reg(3'(r), '0);
		random_phase(25);
		drain();
		no_idle = 0;

		// all-ones extremes, IPv6 peer
		for (int r = 0; r < 8; r++) write_reg(3'(r), '1);
		random_phase(30);
		drain();

		// mixed settings, IPv6 then IPv4 peer
		write_reg(R_TIMEOUT, 2000);
		write_reg(R_RETRY, 20);
		write_reg(R_MAXSYNC, 3);
		write_reg(R_MAXATT, 7);
		write_reg(R_BACKOFF, 5);
		write_reg(R_PEERV6, 1);
		write_reg(R_PEERHI, rnd64());
		write_reg(R_PEERLO, rnd64());
		random_phase(30);
		drain();
		write_reg(R_PEERV6, 0);
		write_reg(R_PEERLO, rnd64());
		write_reg(R_MAXATT, 2);
		write_reg(R_BACKOFF, 1023);
		random_phase(30);
		drain();

		$display("covered %0d requests, %0d results (%0d probes), %0d register writes",
			n_requests, n_results, n_probes, n_cfg);
		$display("sessions ran under default, zero, all-ones and mixed register settings");
		if (errors == 0 && expected_q.size() == 0)
			$display("PASS hole_punch_controller");
		else begin
			if (expected_q.size() > 0) $display("%0d results never came", expected_q.size());
			$display("FAIL hole_punch_controller");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/hpc_pkg.sv
src/hpc_table.sv
src/hpc_out_reg.sv
src/hole_punch_controller.sv
tb/sv/tb_top.sv
